// ===== hdl/hsr_pkg.sv =====
// hsr_pkg: types, constants and romanization tables for the hangul romanizer
// no dependencies; imported by every module of the block except hsr_checker

package hsr_pkg;

  localparam logic [20:0] SYL_FIRST = 21'h00AC00;
  localparam logic [20:0] SYL_LAST  = 21'h00D7A3;

  // reciprocals for offset / 588 and offset / 28, exact over the syllable range
  localparam logic [14:0] RECIP_INI   = 15'd28533;
  localparam int          SHIFT_INI   = 24;
  localparam logic [15:0] RECIP_Q28   = 16'd37450;
  localparam int          SHIFT_Q28   = 20;
  localparam logic [8:0]  MED_PER_INI = 9'd21;
  localparam logic [13:0] PER_MEDIAL  = 14'd28;

  localparam logic [7:0] NUL = 8'h00;

  // classified item between the front and the emitter
  typedef struct packed {
    logic       is_syl;
    logic [7:0] byte_lo;
    logic [4:0] ini;
    logic [4:0] med;
    logic [4:0] fin;
  } hsr_entry_t;

  // up to two letters, c0 goes out first
  typedef struct packed {
    logic [1:0] len;
    logic [7:0] c0;
    logic [7:0] c1;
  } hsr_pair_t;

  // up to three letters, c0 goes out first
  typedef struct packed {
    logic [1:0] len;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
  } hsr_trip_t;

  function automatic hsr_pair_t lead_letters(input logic [4:0] ini);
    hsr_pair_t r;
    unique case (ini)
      5'd0:    r = {2'd1, "g", NUL};
      5'd1:    r = {2'd2, "k", "k"};
      5'd2:    r = {2'd1, "n", NUL};
      5'd3:    r = {2'd1, "d", NUL};
      5'd4:    r = {2'd2, "t", "t"};
      5'd5:    r = {2'd1, "r", NUL};
      5'd6:    r = {2'd1, "m", NUL};
      5'd7:    r = {2'd1, "b", NUL};
      5'd8:    r = {2'd2, "p", "p"};
      5'd9:    r = {2'd1, "s", NUL};
      5'd10:   r = {2'd2, "s", "s"};
      5'd11:   r = {2'd0, NUL, NUL};
      5'd12:   r = {2'd1, "j", NUL};
      5'd13:   r = {2'd2, "j", "j"};
      5'd14:   r = {2'd2, "c", "h"};
      5'd15:   r = {2'd1, "K", NUL};
      5'd16:   r = {2'd1, "T", NUL};
      5'd17:   r = {2'd1, "P", NUL};
      default: r = {2'd1, "h", NUL};
    endcase
    return r;
  endfunction

  function automatic hsr_trip_t vowel_letters(input logic [4:0] med);
    hsr_trip_t r;
    unique case (med)
      5'd0:    r = {2'd1, "a", NUL, NUL};
      5'd1:    r = {2'd2, "a", "e", NUL};
      5'd2:    r = {2'd2, "y", "a", NUL};
      5'd3:    r = {2'd3, "y", "a", "e"};
      5'd4:    r = {2'd2, "e", "o", NUL};
      5'd5:    r = {2'd1, "e", NUL, NUL};
      5'd6:    r = {2'd3, "y", "e", "o"};
      5'd7:    r = {2'd2, "y", "e", NUL};
      5'd8:    r = {2'd1, "o", NUL, NUL};
      5'd9:    r = {2'd2, "w", "a", NUL};
      5'd10:   r = {2'd3, "w", "a", "e"};
      5'd11:   r = {2'd2, "o", "e", NUL};
      5'd12:   r = {2'd2, "y", "o", NUL};
      5'd13:   r = {2'd1, "u", NUL, NUL};
      5'd14:   r = {2'd2, "w", "o", NUL};
      5'd15:   r = {2'd2, "w", "e", NUL};
      5'd16:   r = {2'd2, "w", "i", NUL};
      5'd17:   r = {2'd2, "y", "u", NUL};
      5'd18:   r = {2'd2, "e", "u", NUL};
      5'd19:   r = {2'd2, "u", "i", NUL};
      default: r = {2'd1, "i", NUL, NUL};
    endcase
    return r;
  endfunction

  function automatic hsr_pair_t tail_letters(input logic [4:0] fin);
    hsr_pair_t r;
    unique case (fin)
      5'd1:    r = {2'd1, "k", NUL};
      5'd2:    r = {2'd2, "k", "k"};
      5'd3:    r = {2'd2, "k", "s"};
      5'd4:    r = {2'd1, "n", NUL};
      5'd5:    r = {2'd2, "n", "j"};
      5'd6:    r = {2'd2, "n", "h"};
      5'd7:    r = {2'd1, "t", NUL};
      5'd8:    r = {2'd1, "l", NUL};
      5'd9:    r = {2'd2, "l", "k"};
      5'd10:   r = {2'd2, "l", "m"};
      5'd11:   r = {2'd2, "l", "p"};
      5'd12:   r = {2'd2, "l", "s"};
      5'd13:   r = {2'd2, "l", "T"};
      5'd14:   r = {2'd2, "l", "P"};
      5'd15:   r = {2'd2, "l", "h"};
      5'd16:   r = {2'd1, "m", NUL};
      5'd17:   r = {2'd1, "p", NUL};
      5'd18:   r = {2'd2, "p", "s"};
      5'd19:   r = {2'd1, "s", NUL};
      5'd20:   r = {2'd2, "s", "s"};
      5'd21:   r = {2'd2, "n", "g"};
      5'd22:   r = {2'd1, "j", NUL};
      5'd23:   r = {2'd2, "c", "h"};
      5'd24:   r = {2'd1, "K", NUL};
      5'd25:   r = {2'd1, "T", NUL};
      5'd26:   r = {2'd1, "P", NUL};
      5'd27:   r = {2'd1, "h", NUL};
      default: r = {2'd0, NUL, NUL};
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/hangul_syllable_romanizer_unit.sv =====
// hangul_syllable_romanizer_unit: top level, front classifier, queue and emitter
// depends on hsr_pkg, hsr_front, hsr_fifo and hsr_emit
//
// Usage: one Unicode code point per beat on the input channel
// (in_valid/in_ready/code_point). Each one produces 1 to 7 beats on the
// output channel (out_valid/out_ready/out_byte/last): the letters of a
// precomposed syllable's initial, medial and final, or the low byte of any
// other code point, with last set on the final beat of the item.
// The first byte of an item passes the front's s1 and s2 stages, the queue,
// the emitter's item registers and its output register. Throughput: one
// output byte per cycle while out_ready is high, set by the emitter; input
// beats are taken every cycle while the queue has room, so sustained input is
// bounded by the output, one beat per byte (1 to 7 per syllable, 1 otherwise).
// The front splits syllables in two stages with reciprocal multipliers,
// and a DEPTH-entry queue lets it keep taking items while the output stalls.
// When out_ready is low the output register holds its byte; the emitter,
// queue and front fill in turn, and in_ready drops only once all are full.
// Reset clears all valid flags and queue pointers; no clearing pass is needed.

module hangul_syllable_romanizer_unit #(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [20:0] code_point,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last
);
  import hsr_pkg::*;

  hsr_entry_t f_data;
  hsr_entry_t q_data;
  logic       f_valid;
  logic       f_ready;
  logic       q_valid;
  logic       q_ready;

  hsr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .code_point (code_point),
    .q_valid    (f_valid),
    .q_ready    (f_ready),
    .q_data     (f_data)
  );

  hsr_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  hsr_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .ent_valid (q_valid),
    .ent_ready (q_ready),
    .ent       (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule

// ===== hdl/hsr_front.sv =====
// hsr_front: accepts code points, classifies them and splits syllables
// into initial, medial and final indices over two pipeline stages; uses hsr_pkg

module hsr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [20:0]         code_point,
  output logic                q_valid,
  input  logic                q_ready,
  output hsr_pkg::hsr_entry_t q_data
);
  import hsr_pkg::*;

  logic        s1_v;
  logic        s1_syl;
  logic [7:0]  s1_byte;
  logic [13:0] s1_off;

  logic        s2_v;
  logic        s2_syl;
  logic [7:0]  s2_byte;
  logic [13:0] s2_off;
  logic [4:0]  s2_ini;
  logic [8:0]  s2_q28;

  logic        s1_ready;
  logic        s2_ready;
  logic [20:0] off_full;
  logic [28:0] prod_ini;
  logic [29:0] prod_q28;
  logic [8:0]  med_full;
  logic [13:0] fin_full;

  assign s2_ready = !s2_v || q_ready;
  assign s1_ready = !s1_v || s2_ready;
  assign in_ready = s1_ready;

  assign off_full = code_point - SYL_FIRST;

  // offset / 588 and offset / 28 by reciprocal multiply
  assign prod_ini = 29'(s1_off) * 29'(RECIP_INI);
  assign prod_q28 = 30'(s1_off) * 30'(RECIP_Q28);

  assign med_full = s2_q28 - 9'(s2_ini) * MED_PER_INI;
  assign fin_full = s2_off - 14'(s2_q28) * PER_MEDIAL;

  assign q_valid        = s2_v;
  assign q_data.is_syl  = s2_syl;
  assign q_data.byte_lo = s2_byte;
  assign q_data.ini     = s2_ini;
  assign q_data.med     = med_full[4:0];
  assign q_data.fin     = fin_full[4:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      if (s1_ready) s1_v <= in_valid;
      if (s2_ready) s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_syl  <= (code_point >= SYL_FIRST) && (code_point <= SYL_LAST);
      s1_byte <= code_point[7:0];
      s1_off  <= off_full[13:0];
    end
    if (s1_v && s2_ready) begin
      s2_syl  <= s1_syl;
      s2_byte <= s1_byte;
      s2_off  <= s1_off;
      s2_ini  <= prod_ini[SHIFT_INI +: 5];
      s2_q28  <= prod_q28[SHIFT_Q28 +: 9];
    end
  end

endmodule

// ===== hdl/hsr_fifo.sv =====
// hsr_fifo: short queue of classified items between front and emitter
// uses hsr_pkg for the entry type

module hsr_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  hsr_pkg::hsr_entry_t wr_data,
  output logic                rd_valid,
  input  logic                rd_ready,
  output hsr_pkg::hsr_entry_t rd_data
);
  import hsr_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  hsr_entry_t    slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = (count != FULL_CNT);
  assign rd_valid = (count != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

endmodule

// ===== hdl/hsr_emit.sv =====
// hsr_emit: looks up letters for one classified item and sends them
// one byte per beat through an output register; uses hsr_pkg tables

module hsr_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                ent_valid,
  output logic                ent_ready,
  input  hsr_pkg::hsr_entry_t ent,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                last
);
  import hsr_pkg::*;

  logic      cur_v;
  hsr_pair_t lead_r;
  hsr_trip_t vow_r;
  hsr_pair_t tail_r;
  logic [2:0] idx;
  logic [2:0] total;

  hsr_pair_t  lead_w;
  hsr_trip_t  vow_w;
  hsr_pair_t  tail_w;
  logic [2:0] k_v;
  logic [2:0] k_t;
  logic [7:0] sel;
  logic       adv;
  logic       is_end;
  logic       load;

  assign adv       = cur_v && (!out_valid || out_ready);
  assign is_end    = (idx == total - 3'd1);
  assign ent_ready = !cur_v || (adv && is_end);
  assign load      = ent_valid && ent_ready;

  // non-syllables go out as a single lead letter
  always_comb begin
    if (ent.is_syl) begin
      lead_w = lead_letters(ent.ini);
      vow_w  = vowel_letters(ent.med);
      tail_w = tail_letters(ent.fin);
    end else begin
      lead_w = {2'd1, ent.byte_lo, NUL};
      vow_w  = {2'd0, NUL, NUL, NUL};
      tail_w = {2'd0, NUL, NUL};
    end
  end

  assign k_v = idx - {1'b0, lead_r.len};
  assign k_t = k_v - {1'b0, vow_r.len};

  always_comb begin
    if (idx < {1'b0, lead_r.len}) begin
      sel = idx[0] ? lead_r.c1 : lead_r.c0;
    end else if (k_v < {1'b0, vow_r.len}) begin
      case (k_v[1:0])
        2'd0:    sel = vow_r.c0;
        2'd1:    sel = vow_r.c1;
        default: sel = vow_r.c2;
      endcase
    end else begin
      sel = k_t[0] ? tail_r.c1 : tail_r.c0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_v     <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (ent_ready) cur_v <= ent_valid;
      if (load) idx <= '0;
      else if (adv) idx <= idx + 3'd1;
      if (adv) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lead_r <= lead_w;
      vow_r  <= vow_w;
      tail_r <= tail_w;
      total  <= {1'b0, lead_w.len} + {1'b0, vow_w.len} + {1'b0, tail_w.len};
    end
    if (adv) begin
      out_byte <= sel;
      last     <= is_end;
    end
  end

endmodule

// ===== hdl/hsr_checker.sv =====
// hsr_checker: port-level assertions for the hangul romanizer
// bound to hangul_syllable_romanizer_unit; no package needed

module hsr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        last
);

  // items taken in whose last beat has not gone out yet
  logic [7:0] pending;
  logic       in_beat;
  logic       last_beat;

  assign in_beat   = in_valid && in_ready;
  assign last_beat = out_valid && out_ready && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_beat && !last_beat) begin
      pending <= pending + 8'd1;
    end else if (last_beat && !in_beat) begin
      pending <= pending - 8'd1;
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pending != 8'd0))
    else $error("output beat with no item outstanding");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    (pending == 8'd0) |-> in_ready)
    else $error("input stalled while block is empty");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
    else $error("stalled output beat changed");

endmodule

bind hangul_syllable_romanizer_unit hsr_checker u_hsr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_byte   (out_byte),
  .last       (last)
);

// ===== tb/sv/hangul_syllable_romanizer_unit_test.sv =====
// hangul_syllable_romanizer_unit_test: self-checking bench for the hangul romanizer
// predicts the romanized byte stream per code point and checks every output beat
// depends on hsr_pkg and hangul_syllable_romanizer_unit

module hangul_syllable_romanizer_unit_test;
  import hsr_pkg::*;

  localparam int INI_STRIDE = 588;
  localparam int MED_STRIDE = 28;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int RANDOM_ITEMS = 350;

  typedef struct packed {
    logic [7:0] letter;
    logic       last;
  } romaja_beat_t;

  class romaja_scoreboard;
    romaja_beat_t expected_beats[$];
    int errors;
    int code_points;
    int syllables;
    int bytes_checked;

    function string lead_romaja(int idx);
      case (idx)
        0: return "g";    1: return "kk";   2: return "n";    3: return "d";
        4: return "tt";   5: return "r";    6: return "m";    7: return "b";
        8: return "pp";   9: return "s";    10: return "ss";  11: return "";
        12: return "j";   13: return "jj";  14: return "ch";  15: return "K";
        16: return "T";   17: return "P";
        default: return "h";
      endcase
    endfunction

    function string vowel_romaja(int idx);
      case (idx)
        0: return "a";    1: return "ae";   2: return "ya";   3: return "yae";
        4: return "eo";   5: return "e";    6: return "yeo";  7: return "ye";
        8: return "o";    9: return "wa";   10: return "wae"; 11: return "oe";
        12: return "yo";  13: return "u";   14: return "wo";  15: return "we";
        16: return "wi";  17: return "yu";  18: return "eu";  19: return "ui";
        default: return "i";
      endcase
    endfunction

    function string tail_romaja(int idx);
      case (idx)
        1: return "k";    2: return "kk";   3: return "ks";   4: return "n";
        5: return "nj";   6: return "nh";   7: return "t";    8: return "l";
        9: return "lk";   10: return "lm";  11: return "lp";  12: return "ls";
        13: return "lT";  14: return "lP";  15: return "lh";  16: return "m";
        17: return "p";   18: return "ps";  19: return "s";   20: return "ss";
        21: return "ng";  22: return "j";   23: return "ch";  24: return "K";
        25: return "T";   26: return "P";   27: return "h";
        default: return "";
      endcase
    endfunction

    function void note_code_point(logic [20:0] cp);
      int ofs;
      int i;
      string letters;
      romaja_beat_t bt;
      code_points++;
      if (cp < SYL_FIRST || cp > SYL_LAST) begin
        bt.letter = cp[7:0];
        bt.last = 1'b1;
        expected_beats.push_back(bt);
        return;
      end
      syllables++;
      ofs = int'(cp - SYL_FIRST);
      letters = {lead_romaja(ofs / INI_STRIDE),
                 vowel_romaja((ofs % INI_STRIDE) / MED_STRIDE),
                 tail_romaja(ofs % MED_STRIDE)};
      for (i = 0; i < letters.len(); i++) begin
        bt.letter = letters[i];
        bt.last = (i == letters.len() - 1);
        expected_beats.push_back(bt);
      end
    endfunction

    function void check_beat(logic [7:0] got_byte, logic got_last);
      romaja_beat_t want;
      if (expected_beats.size() == 0) begin
        $error("unexpected output beat: out_byte %h last %b", got_byte, got_last);
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      bytes_checked++;
      if (got_byte !== want.letter) begin
        $error("out_byte: expected %h, actual %h", want.letter, got_byte);
        errors++;
      end
      if (got_last !== want.last) begin
        $error("last: expected %b, actual %b", want.last, got_last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [20:0] code_point;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        last;

  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_off_req;
  int hold_offs_done;

  romaja_scoreboard sb = new();

  hangul_syllable_romanizer_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .code_point(code_point),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [20:0] make_syllable(int ini, int med, int fin);
    return SYL_FIRST + 21'(ini * INI_STRIDE + med * MED_STRIDE + fin);
  endfunction

  function automatic logic [20:0] random_code_point();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick <= 5)
      return make_syllable($urandom_range(0, 18), $urandom_range(0, 20),
                           $urandom_range(0, 27));
    else if (pick == 6)
      case ($urandom_range(0, 3))
        0: return SYL_FIRST - 21'd1;
        1: return SYL_FIRST;
        2: return SYL_LAST;
        default: return SYL_LAST + 21'd1;
      endcase
    else if (pick == 7)
      return 21'($urandom_range(0, 255));
    else
      return 21'($urandom);
  endfunction

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_code_point(input logic [20:0] cp);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid = 1'b1;
    code_point = cp;
    do @(posedge clk); while (!in_ready);
    sb.note_code_point(cp);
    @(negedge clk);
  endtask

  // receiver: random ready bursts, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      if (hold_off_req && hold_offs_done == 0) begin
        out_ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_offs_done++;
      end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_beat(out_byte, last);
  end

  initial begin
    logic [20:0] directed_cps[$];
    int n;
    rst = 1'b1;
    in_valid = 1'b0;
    code_point = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_off_req = 1'b0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    directed_cps = '{
      21'h000000, 21'h1FFFFF, 21'h10FFFF, 21'h110000, 21'h0000FF, 21'h000041,
      SYL_FIRST - 21'd1, SYL_FIRST, SYL_LAST, SYL_LAST + 21'd1,
      make_syllable(11, 0, 0),     // empty initial and final: one byte
      make_syllable(11, 20, 27),
      make_syllable(1, 3, 2),      // seven bytes
      make_syllable(14, 10, 23),
      make_syllable(15, 0, 13),    // uppercase aspirates
      make_syllable(16, 8, 14),
      make_syllable(17, 13, 24),
      make_syllable(18, 20, 25),
      make_syllable(0, 19, 26),
      make_syllable(11, 6, 21),
      make_syllable(9, 16, 0),
      21'h0AAAAA, 21'h155555
    };
    foreach (directed_cps[i])
      send_code_point(directed_cps[i]);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // long stall on the output while input keeps coming, to fill the queue
      if (n == 120)
        hold_off_req = 1'b1;
      if (n == RANDOM_ITEMS - 60) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      send_code_point(random_code_point());
    end
    in_valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("checked %0d code points (%0d syllables), %0d output bytes",
             sb.code_points, sb.syllables, sb.bytes_checked);
    $display("random idling on both sides, %0d long output hold-off(s)", hold_offs_done);
    if (sb.errors == 0)
      $display("hangul_syllable_romanizer_unit_test passed");
    else
      $display("hangul_syllable_romanizer_unit_test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout waiting for the block");
    $display("hangul_syllable_romanizer_unit_test failed");
    $finish;
  end

endmodule
